// ===== design/anb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// anb_pkg
// Shared types and constants of the Annex-B NAL unit splitter.
// ----------------------------------------------------------------------------
package anb_pkg;

    localparam int DEF_LENGTH_BITS = 24;
    localparam int DEF_QUEUE_DEPTH = 4;

    localparam int OUT_LEN_W = 24;
    localparam int TYPE_W    = 6;
    localparam int KIND_W    = 2;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;

    localparam logic [7:0] AVC_TYPE_MASK  = 8'h1F;
    localparam logic [7:0] HEVC_TYPE_MASK = 8'h3F;

    localparam logic [TYPE_W-1:0] AVC_TYPE_SPS  = 6'd7;
    localparam logic [TYPE_W-1:0] AVC_TYPE_PPS  = 6'd8;
    localparam logic [TYPE_W-1:0] HEVC_TYPE_VPS = 6'd32;
    localparam logic [TYPE_W-1:0] HEVC_TYPE_SPS = 6'd33;
    localparam logic [TYPE_W-1:0] HEVC_TYPE_PPS = 6'd34;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VPS  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SPS  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_PPS  = 2'd3;

    localparam logic CODEC_AVC  = 1'b0;
    localparam logic CODEC_HEVC = 1'b1;

    typedef struct packed {
        logic       unit_valid;
        logic       packet_end;
        logic [7:0] header_byte;
    } t_ev_ctl;

endpackage
`default_nettype wire

// ===== design/annexb_nal_unit_splitter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter
// Splits an Annex-B byte stream into NAL units and reports each unit's
// length, header type and parameter-set kind.
//
// Input side is a queue write port: one byte per transaction, taken when
// push is high and full is low; i_last_byte marks the packet's last byte.
// Result side is a queue read port: the oldest result sits on the o_ ports
// while empty is low and is taken when pop is high.
// The parser handles one byte per cycle while full is low. A byte that ends
// a unit passes through the event queue and then the output register.
// Results wait in a four-entry event queue plus the output register, so
// the parser keeps taking bytes while the receiver stalls; full rises
// only once the event queue is full.
// i_cfg_we writes i_cfg_data to the codec mode (0 H.264, 1 H.265); write it
// only while no results are pending.
// Reset clears parse state, the queue and the codec mode; no result is
// pending after reset.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter #(
    parameter int LENGTH_BITS = anb_pkg::DEF_LENGTH_BITS,
    parameter int QUEUE_DEPTH = anb_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_data,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic                          i_last_byte,
    input  wire logic                          pop,
    output logic                               empty,
    output logic                               o_unit_valid,
    output logic [anb_pkg::OUT_LEN_W-1:0]      o_unit_length,
    output logic [anb_pkg::TYPE_W-1:0]         o_unit_type,
    output logic [anb_pkg::KIND_W-1:0]         o_param_kind,
    output logic                               o_packet_end
);

    localparam int CTL_W = $bits(anb_pkg::t_ev_ctl);
    localparam int EV_W  = LENGTH_BITS + CTL_W;

    logic                   accept;
    anb_pkg::t_ev_ctl       f_ctl;
    logic [LENGTH_BITS-1:0] f_len;
    logic                   f_push;
    logic [EV_W-1:0]        q_rdata;
    logic                   q_nonempty;
    logic                   b_take;
    anb_pkg::t_ev_ctl       b_ctl;
    logic [LENGTH_BITS-1:0] b_len;

    assign accept = push && !full;
    assign b_ctl  = anb_pkg::t_ev_ctl'(q_rdata[EV_W-1:LENGTH_BITS]);
    assign b_len  = q_rdata[LENGTH_BITS-1:0];

    anb_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_ev_ctl    (f_ctl),
        .o_ev_len    (f_len),
        .o_ev_push   (f_push)
    );

    anb_queue #(
        .DATA_W (EV_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (f_push),
        .i_wdata    ({f_ctl, f_len}),
        .i_rd       (b_take),
        .o_rdata    (q_rdata),
        .o_full     (full),
        .o_nonempty (q_nonempty)
    );

    anb_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_ev_avail    (q_nonempty),
        .i_ev_ctl      (b_ctl),
        .i_ev_len      (b_len),
        .o_ev_take     (b_take),
        .pop           (pop),
        .empty         (empty),
        .o_unit_valid  (o_unit_valid),
        .o_unit_length (o_unit_length),
        .o_unit_type   (o_unit_type),
        .o_param_kind  (o_param_kind),
        .o_packet_end  (o_packet_end)
    );

endmodule
`default_nettype wire

// ===== design/anb_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// anb_front
// Byte parser: tracks start codes and unit length, posts unit-end events.
// ----------------------------------------------------------------------------
module anb_front #(
    parameter int LENGTH_BITS = anb_pkg::DEF_LENGTH_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_accept,
    input  wire logic [7:0]             i_data_byte,
    input  wire logic                   i_last_byte,
    output anb_pkg::t_ev_ctl            o_ev_ctl,
    output logic [LENGTH_BITS-1:0]      o_ev_len,
    output logic                        o_ev_push
);

    localparam logic [LENGTH_BITS-1:0] LEN_CAP = {LENGTH_BITS{1'b1}};

    logic                   r_inside;
    logic [1:0]             r_zrun;
    logic [LENGTH_BITS-1:0] r_count;
    logic [7:0]             r_hdr;
    logic                   r_cap;

    logic                   n_inside;
    logic [1:0]             n_zrun;
    logic [LENGTH_BITS-1:0] n_count;
    logic [7:0]             n_hdr;
    logic                   n_cap;

    logic                   is_sc;
    logic [2:0]             inc;
    logic [LENGTH_BITS:0]   sum_a;
    logic [LENGTH_BITS-1:0] body_count;
    logic [1:0]             zrun_step;
    logic [LENGTH_BITS:0]   sum_b;
    logic [LENGTH_BITS-1:0] total;

    assign is_sc = (i_data_byte == anb_pkg::BYTE_ONE) && (r_zrun >= 2'd2);

    always_comb begin
        if (i_data_byte == anb_pkg::BYTE_ZERO) begin
            inc = (r_zrun == 2'd3) ? 3'd1 : 3'd0;
        end else begin
            inc = {1'b0, r_zrun} + 3'd1;
        end
    end

    assign sum_a      = {1'b0, r_count} + (LENGTH_BITS+1)'(inc);
    assign body_count = !r_inside ? r_count :
                        (sum_a[LENGTH_BITS] ? LEN_CAP : sum_a[LENGTH_BITS-1:0]);

    always_comb begin
        if (i_data_byte == anb_pkg::BYTE_ZERO) begin
            zrun_step = (r_zrun == 2'd3) ? r_zrun : r_zrun + 2'd1;
        end else begin
            zrun_step = 2'd0;
        end
    end

    assign sum_b = {1'b0, body_count} + (LENGTH_BITS+1)'(zrun_step);
    assign total = !r_inside ? '0 :
                   (sum_b[LENGTH_BITS] ? LEN_CAP : sum_b[LENGTH_BITS-1:0]);

    always_comb begin
        o_ev_push            = 1'b0;
        o_ev_ctl.unit_valid  = 1'b0;
        o_ev_ctl.packet_end  = i_last_byte;
        o_ev_ctl.header_byte = r_hdr;
        o_ev_len             = '0;
        n_inside             = r_inside;
        n_zrun               = r_zrun;
        n_count              = r_count;
        n_hdr                = r_hdr;
        n_cap                = r_cap;
        if (is_sc) begin
            if (r_inside && (r_count != '0)) begin
                o_ev_push           = i_accept;
                o_ev_ctl.unit_valid = 1'b1;
                o_ev_len            = r_count;
            end else if (i_last_byte) begin
                o_ev_push = i_accept;
            end
            n_inside = !i_last_byte;
            n_zrun   = 2'd0;
            n_count  = '0;
            n_hdr    = '0;
            n_cap    = 1'b0;
        end else if (i_last_byte) begin
            o_ev_push = i_accept;
            if (r_inside && !r_cap) begin
                o_ev_ctl.header_byte = i_data_byte;
            end
            if (total != '0) begin
                o_ev_ctl.unit_valid = 1'b1;
                o_ev_len            = total;
            end
            n_inside = 1'b0;
            n_zrun   = 2'd0;
            n_count  = '0;
            n_hdr    = '0;
            n_cap    = 1'b0;
        end else begin
            if (i_data_byte == anb_pkg::BYTE_ZERO) begin
                n_zrun = (r_zrun == 2'd3) ? r_zrun : r_zrun + 2'd1;
            end else begin
                n_zrun = 2'd0;
            end
            n_count = body_count;
            if (r_inside && !r_cap) begin
                n_hdr = i_data_byte;
                n_cap = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_zrun   <= 2'd0;
            r_count  <= '0;
            r_hdr    <= '0;
            r_cap    <= 1'b0;
        end else if (i_accept) begin
            r_inside <= n_inside;
            r_zrun   <= n_zrun;
            r_count  <= n_count;
            r_hdr    <= n_hdr;
            r_cap    <= n_cap;
        end
    end

endmodule
`default_nettype wire

// ===== design/anb_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// anb_queue
// Small FIFO of unit-end events between the parser and the result stage.
// ----------------------------------------------------------------------------
module anb_queue #(
    parameter int DATA_W = 34,
    parameter int DEPTH  = anb_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_rd,
    output logic [DATA_W-1:0]      o_rdata,
    output logic                   o_full,
    output logic                   o_nonempty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_cnt;

    logic wr_en;
    logic rd_en;

    assign o_full     = (r_cnt == CNT_FULL);
    assign o_nonempty = (r_cnt != '0);
    assign wr_en      = i_wr && !o_full;
    assign rd_en      = i_rd && o_nonempty;
    assign o_rdata    = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + PTR_W'(1);
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + PTR_W'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/anb_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// anb_back
// Result stage: decodes unit type and parameter-set kind, holds the result.
// ----------------------------------------------------------------------------
module anb_back #(
    parameter int LENGTH_BITS = anb_pkg::DEF_LENGTH_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_data,
    input  wire logic                          i_ev_avail,
    input  wire anb_pkg::t_ev_ctl              i_ev_ctl,
    input  wire logic [LENGTH_BITS-1:0]        i_ev_len,
    output logic                               o_ev_take,
    input  wire logic                          pop,
    output logic                               empty,
    output logic                               o_unit_valid,
    output logic [anb_pkg::OUT_LEN_W-1:0]      o_unit_length,
    output logic [anb_pkg::TYPE_W-1:0]         o_unit_type,
    output logic [anb_pkg::KIND_W-1:0]         o_param_kind,
    output logic                               o_packet_end
);

    logic r_codec_mode;
    logic r_full;

    logic [anb_pkg::TYPE_W-1:0] n_type;
    logic [anb_pkg::KIND_W-1:0] n_kind;
    logic [7:0]                 hdr_shift;
    logic                       long_unit;
    logic [31:0]                len_ext;

    assign o_ev_take = i_ev_avail && (!r_full || pop);
    assign empty     = !r_full;
    assign long_unit = (i_ev_len > LENGTH_BITS'(1));
    assign len_ext   = 32'(i_ev_len);
    assign hdr_shift = i_ev_ctl.header_byte >> 1;

    always_comb begin
        n_type = '0;
        n_kind = anb_pkg::KIND_NONE;
        if (i_ev_ctl.unit_valid) begin
            if (r_codec_mode == anb_pkg::CODEC_HEVC) begin
                n_type = anb_pkg::TYPE_W'(hdr_shift & anb_pkg::HEVC_TYPE_MASK);
                if (long_unit) begin
                    case (n_type)
                        anb_pkg::HEVC_TYPE_VPS: n_kind = anb_pkg::KIND_VPS;
                        anb_pkg::HEVC_TYPE_SPS: n_kind = anb_pkg::KIND_SPS;
                        anb_pkg::HEVC_TYPE_PPS: n_kind = anb_pkg::KIND_PPS;
                        default:                n_kind = anb_pkg::KIND_NONE;
                    endcase
                end
            end else begin
                n_type = anb_pkg::TYPE_W'(i_ev_ctl.header_byte & anb_pkg::AVC_TYPE_MASK);
                if (long_unit) begin
                    case (n_type)
                        anb_pkg::AVC_TYPE_SPS: n_kind = anb_pkg::KIND_SPS;
                        anb_pkg::AVC_TYPE_PPS: n_kind = anb_pkg::KIND_PPS;
                        default:               n_kind = anb_pkg::KIND_NONE;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec_mode <= anb_pkg::CODEC_AVC;
            r_full       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_codec_mode <= i_cfg_data;
            end
            if (o_ev_take) begin
                r_full <= 1'b1;
            end else if (pop) begin
                r_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ev_take) begin
            o_unit_valid  <= i_ev_ctl.unit_valid;
            o_unit_length <= i_ev_ctl.unit_valid ? len_ext[anb_pkg::OUT_LEN_W-1:0] : '0;
            o_unit_type   <= n_type;
            o_param_kind  <= n_kind;
            o_packet_end  <= i_ev_ctl.packet_end;
        end
    end

endmodule
`default_nettype wire

// ===== sim/tb_annexb_nal_unit_splitter.sv =====
// ----------------------------------------------------------------------------
// tb_annexb_nal_unit_splitter
// Self-checking bench for the Annex-B NAL unit splitter. A short table of
// directed packets covers start-code corner cases in both codec modes, then
// random packets, mostly well formed with random unit content and some
// noise, are streamed under three sender/receiver throttling profiles. A
// byte-level predictor computes every result transaction, and results
// are compared in order against it.
// ----------------------------------------------------------------------------
module tb_annexb_nal_unit_splitter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint LEN_CAP       = (longint'(1) << anb_pkg::DEF_LENGTH_BITS) - 1;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     SEGMENT_BYTES = 238;
    localparam int     MAX_REPORTED  = 10;

    localparam logic [7:0]                 BYTE_EPB        = 8'h03;
    localparam logic [anb_pkg::TYPE_W-1:0] AVC_TYPE_SLICE  = 6'd1;
    localparam logic [anb_pkg::TYPE_W-1:0] AVC_TYPE_IDR    = 6'd5;
    localparam logic [anb_pkg::TYPE_W-1:0] HEVC_TYPE_TRAIL = 6'd1;
    localparam logic [anb_pkg::TYPE_W-1:0] HEVC_TYPE_IDR   = 6'd19;

    typedef struct packed {
        logic                          valid;
        logic [anb_pkg::OUT_LEN_W-1:0] length;
        logic [anb_pkg::TYPE_W-1:0]    utype;
        logic [anb_pkg::KIND_W-1:0]    kind;
        logic                          pend;
    } t_nal_report;

    typedef struct packed {
        logic        mode;
        logic [7:0]  data;
        logic        last;
        logic        typed;
        t_nal_report want;
    } t_stim_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_data  = 1'b0;
    logic       push        = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_last_byte = 1'b0;
    logic       pop         = 1'b0;

    wire                          full;
    wire                          empty;
    wire                          o_unit_valid;
    wire [anb_pkg::OUT_LEN_W-1:0] o_unit_length;
    wire [anb_pkg::TYPE_W-1:0]    o_unit_type;
    wire [anb_pkg::KIND_W-1:0]    o_param_kind;
    wire                          o_packet_end;

    // predictor state
    logic       codec_mode = anb_pkg::CODEC_AVC;
    logic       in_unit    = 1'b0;
    logic [1:0] zero_run   = 2'd0;
    longint     unit_len   = 0;
    logic [7:0] hdr_byte   = 8'h00;
    logic       hdr_seen   = 1'b0;

    t_nal_report pending_reports[$];
    int          n_predicted   = 0;
    int          n_fail        = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          seg_bytes     = 0;

    annexb_nal_unit_splitter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .pop           (pop),
        .empty         (empty),
        .o_unit_valid  (o_unit_valid),
        .o_unit_length (o_unit_length),
        .o_unit_type   (o_unit_type),
        .o_param_kind  (o_param_kind),
        .o_packet_end  (o_packet_end)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_nal_report rpt(logic v, logic [anb_pkg::OUT_LEN_W-1:0] len,
                                        logic [anb_pkg::TYPE_W-1:0] t,
                                        logic [anb_pkg::KIND_W-1:0] k, logic pe);
        t_nal_report r;
        r.valid  = v;
        r.length = len;
        r.utype  = t;
        r.kind   = k;
        r.pend   = pe;
        return r;
    endfunction

    function automatic t_stim_row row(logic m, logic [7:0] d, logic l = 1'b0,
                                      logic typed = 1'b0, t_nal_report want = '0);
        t_stim_row s;
        s.mode  = m;
        s.data  = d;
        s.last  = l;
        s.typed = typed;
        s.want  = want;
        return s;
    endfunction

    function automatic longint sat_len(longint s);
        return (s > LEN_CAP) ? LEN_CAP : s;
    endfunction

    function automatic void add_report(t_nal_report r);
        pending_reports.insert(pending_reports.size(), r);
        n_predicted++;
    endfunction

    function automatic void restart_unit();
        zero_run = 2'd0;
        unit_len = 0;
        hdr_byte = 8'h00;
        hdr_seen = 1'b0;
    endfunction

    function automatic void close_unit(logic v, longint len, logic pe);
        logic [anb_pkg::TYPE_W-1:0] t;
        logic [anb_pkg::KIND_W-1:0] k;
        t = '0;
        k = anb_pkg::KIND_NONE;
        if (v) begin
            if (codec_mode == anb_pkg::CODEC_HEVC) begin
                t = anb_pkg::TYPE_W'((hdr_byte >> 1) & anb_pkg::HEVC_TYPE_MASK);
                if (len > 1) begin
                    case (t)
                        anb_pkg::HEVC_TYPE_VPS: k = anb_pkg::KIND_VPS;
                        anb_pkg::HEVC_TYPE_SPS: k = anb_pkg::KIND_SPS;
                        anb_pkg::HEVC_TYPE_PPS: k = anb_pkg::KIND_PPS;
                        default: k = anb_pkg::KIND_NONE;
                    endcase
                end
            end else begin
                t = anb_pkg::TYPE_W'(hdr_byte & anb_pkg::AVC_TYPE_MASK);
                if (len > 1) begin
                    case (t)
                        anb_pkg::AVC_TYPE_SPS: k = anb_pkg::KIND_SPS;
                        anb_pkg::AVC_TYPE_PPS: k = anb_pkg::KIND_PPS;
                        default: k = anb_pkg::KIND_NONE;
                    endcase
                end
            end
        end else begin
            len = 0;
        end
        add_report(rpt(v, len[anb_pkg::OUT_LEN_W-1:0], t, k, pe));
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic last);
        longint total;
        if (b == anb_pkg::BYTE_ONE && zero_run >= 2'd2) begin
            if (in_unit && unit_len > 0) begin
                close_unit(1'b1, unit_len, last);
            end else if (last) begin
                close_unit(1'b0, 0, 1'b1);
            end
            in_unit = !last;
            restart_unit();
            return;
        end
        if (in_unit && !hdr_seen) begin
            hdr_byte = b;
            hdr_seen = 1'b1;
        end
        if (b == anb_pkg::BYTE_ZERO) begin
            // a fourth zero and beyond belongs to the current unit
            if (zero_run == 2'd3) begin
                if (in_unit) unit_len = sat_len(unit_len + 1);
            end else begin
                zero_run = zero_run + 2'd1;
            end
        end else begin
            if (in_unit) unit_len = sat_len(unit_len + longint'(zero_run) + 1);
            zero_run = 2'd0;
        end
        if (last) begin
            total = in_unit ? sat_len(unit_len + longint'(zero_run)) : 0;
            close_unit(total > 0, total, 1'b1);
            in_unit = 1'b0;
            restart_unit();
        end
    endfunction

    function automatic void check_report();
        t_nal_report got;
        t_nal_report want;
        got = rpt(o_unit_valid, o_unit_length, o_unit_type, o_param_kind, o_packet_end);
        if (pending_reports.size() == 0) begin
            if (n_fail < MAX_REPORTED)
                $display("%0t: unexpected unit: valid %b len %0d type %0d kind %0d end %b",
                         $realtime, got.valid, got.length, got.utype, got.kind, got.pend);
            n_fail++;
            return;
        end
        want = pending_reports.pop_front();
        if (got !== want) begin
            if (n_fail < MAX_REPORTED) begin
                $display("%0t: unit mismatch", $realtime);
                $display("  expected: valid %b len %0d type %0d kind %0d end %b",
                         want.valid, want.length, want.utype, want.kind, want.pend);
                $display("  actual:   valid %b len %0d type %0d kind %0d end %b",
                         got.valid, got.length, got.utype, got.kind, got.pend);
            end
            n_fail++;
        end
    endfunction

    function automatic logic [7:0] pick_header();
        logic [anb_pkg::TYPE_W-1:0] t;
        if ($urandom_range(3) == 0) return 8'($urandom_range(255));
        if (codec_mode == anb_pkg::CODEC_HEVC) begin
            case ($urandom_range(4))
                0: t = anb_pkg::HEVC_TYPE_VPS;
                1: t = anb_pkg::HEVC_TYPE_SPS;
                2: t = anb_pkg::HEVC_TYPE_PPS;
                3: t = HEVC_TYPE_IDR;
                default: t = HEVC_TYPE_TRAIL;
            endcase
            return {1'($urandom_range(1)), t, 1'($urandom_range(1))};
        end
        case ($urandom_range(3))
            0: t = anb_pkg::AVC_TYPE_SPS;
            1: t = anb_pkg::AVC_TYPE_PPS;
            2: t = AVC_TYPE_IDR;
            default: t = AVC_TYPE_SLICE;
        endcase
        return {3'($urandom_range(7)), t[4:0]};
    endfunction

    function automatic logic [7:0] pick_body();
        case ($urandom_range(5))
            0: return anb_pkg::BYTE_ZERO;
            1: return BYTE_EPB;
            2: return anb_pkg::BYTE_ONE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_byte(logic [7:0] b, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        parse_byte(b, last);
        seg_bytes++;
    endtask

    // hold input until every pending unit has drained, then write the mode
    task automatic set_codec(logic m);
        push <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        codec_mode = m;
    endtask

    task automatic send_packet();
        logic [7:0] pkt[$];
        int         n_len;
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 16)) pkt.insert(pkt.size(), pick_body());
        end else begin
            repeat ($urandom_range(2)) pkt.insert(pkt.size(), pick_body());
            repeat ($urandom_range(1, 4)) begin
                repeat (($urandom_range(9) == 0) ? $urandom_range(4, 6) : $urandom_range(2, 3))
                    pkt.insert(pkt.size(), anb_pkg::BYTE_ZERO);
                pkt.insert(pkt.size(), anb_pkg::BYTE_ONE);
                n_len = $urandom_range(1, 12);
                if ($urandom_range(9) == 0) n_len = 0;
                else if ($urandom_range(59) == 0) n_len = $urandom_range(100, 400);
                if (n_len > 0) pkt.insert(pkt.size(), pick_header());
                repeat ((n_len > 0) ? n_len - 1 : 0) pkt.insert(pkt.size(), pick_body());
                if ($urandom_range(4) == 0)
                    repeat ($urandom_range(1, 4)) pkt.insert(pkt.size(), anb_pkg::BYTE_ZERO);
            end
            if ($urandom_range(7) == 0) begin
                pkt.insert(pkt.size(), anb_pkg::BYTE_ZERO);
                pkt.insert(pkt.size(), anb_pkg::BYTE_ZERO);
                pkt.insert(pkt.size(), anb_pkg::BYTE_ONE);
            end
        end
        foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) check_report();
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_stim_row stim_rows[$];
        int        n_before;

        // packet without any start code
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_AVC, 8'hFF, 1'b1, 1'b1,
            rpt(1'b0, '0, '0, anb_pkg::KIND_NONE, 1'b1)));
        // empty unit inside a packet, then SPS closed after a long zero run
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_AVC, 8'h00));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_AVC, 8'h00));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_AVC, 8'h01));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_AVC, 8'h00));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_AVC, 8'h00));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_AVC, 8'h01));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_AVC, 8'h67));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_AVC, 8'h00));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_AVC, 8'h00));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_AVC, 8'h00));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_AVC, 8'h00));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_AVC, 8'h01, 1'b0, 1'b1,
            rpt(1'b1, anb_pkg::OUT_LEN_W'(2), anb_pkg::AVC_TYPE_SPS,
                anb_pkg::KIND_SPS, 1'b0)));
        // PPS with trailing zeros at packet end
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_AVC, 8'hE8));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_AVC, 8'h00));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_AVC, 8'h00, 1'b1, 1'b1,
            rpt(1'b1, anb_pkg::OUT_LEN_W'(3), anb_pkg::AVC_TYPE_PPS,
                anb_pkg::KIND_PPS, 1'b1)));
        // HEVC PPS, then an empty unit closed by a start code on the last byte
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_HEVC, 8'h00));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_HEVC, 8'h00));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_HEVC, 8'h01));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_HEVC, 8'h44));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_HEVC, 8'h01));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_HEVC, 8'h00));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_HEVC, 8'h00));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_HEVC, 8'h01, 1'b0, 1'b1,
            rpt(1'b1, anb_pkg::OUT_LEN_W'(2), anb_pkg::HEVC_TYPE_PPS,
                anb_pkg::KIND_PPS, 1'b0)));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_HEVC, 8'h00));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_HEVC, 8'h00));
        stim_rows.insert(stim_rows.size(), row(anb_pkg::CODEC_HEVC, 8'h01, 1'b1, 1'b1,
            rpt(1'b0, '0, '0, anb_pkg::KIND_NONE, 1'b1)));

        send_idle_pct = 36;
        recv_idle_pct = 63;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_codec(anb_pkg::CODEC_AVC);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].mode != codec_mode) set_codec(stim_rows[i].mode);
            n_before = n_predicted;
            send_byte(stim_rows[i].data, stim_rows[i].last);
            if (stim_rows[i].typed) begin
                if (n_predicted > n_before)
                    pending_reports[pending_reports.size() - 1] = stim_rows[i].want;
                else
                    add_report(stim_rows[i].want);
            end
        end

        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 36 : (p == 1) ? 63 : 0;
            recv_idle_pct = (p == 0) ? 63 : (p == 1) ? 36 : 0;
            for (int m = 0; m < 2; m++) begin
                set_codec((m == 0) ? anb_pkg::CODEC_AVC : anb_pkg::CODEC_HEVC);
                seg_bytes = 0;
                while (seg_bytes < SEGMENT_BYTES) send_packet();
            end
        end

        push <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES * 4) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== annexb_nal_unit_splitter.f =====
design/anb_pkg.sv
design/anb_front.sv
design/anb_queue.sv
design/anb_back.sv
design/annexb_nal_unit_splitter.sv
sim/tb_annexb_nal_unit_splitter.sv
